/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on the block clock, held off during reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds on the block clock
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* sv/kwm_pkg.sv */
package kwm_pkg;

	localparam int ROWS_DEF = 4;
	localparam int DATA_W   = 32;
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_FETCH,
		ST_CUR_LD,
		ST_SIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     vld;
		logic                     last;
		logic signed [DATA_W-1:0] value;
	} emit_t;

endpackage

/* sv/kwm_matrix_mem.sv */
module kwm_matrix_mem import kwm_pkg::*; #(
	parameter int DEPTH = ROWS_DEF * ROWS_DEF,
	parameter int AW    = $clog2(ROWS_DEF * ROWS_DEF)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            wa,
	input  logic signed [DATA_W-1:0] wd,
	input  logic [AW-1:0]            ra,
	output logic signed [DATA_W-1:0] rd
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd <= mem[ra];
	end

endmodule

/* sv/kwm_heap_mem.sv */
module kwm_heap_mem import kwm_pkg::*; #(
	parameter int DEPTH = ROWS_DEF,
	parameter int AW    = $clog2(ROWS_DEF),
	parameter int W     = DATA_W + 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [W-1:0]  wd,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	output logic [W-1:0]  rd0,
	output logic [W-1:0]  rd1
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

endmodule

/* sv/kwm_ctrl.sv */
`include "assert_macros.svh"

module kwm_ctrl import kwm_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int MAW  = $clog2(ROWS_DEF * ROWS_DEF)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     out_free,
	output logic                     idle,
	output emit_t                    em,
	output logic [MAW-1:0]           mx_ra,
	input  logic signed [DATA_W-1:0] mx_rd
);

	localparam int HW  = $clog2(ROWS);
	localparam int NCW = $clog2(ROWS + 1);
	localparam int CW  = HW + 2;
	localparam int CNW = $clog2(ROWS * ROWS);

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic [HW-1:0]            row;
		logic [NCW-1:0]           ncol;
	} ent_t;

	localparam int EW = $bits(ent_t);

	typedef enum logic [1:0] {
		SEL_SELF,
		SEL_LEFT,
		SEL_RIGHT
	} sel_t;

	state_t         state_q, state_d;
	logic [HW-1:0]  idx_q, idx_d;
	logic [HW-1:0]  pos_q, pos_d;
	logic [CNW-1:0] emit_q, emit_d;
	logic           build_q, build_d;
	ent_t           cur_q, cur_d;
	ent_t           root_q, root_d;
	logic [HW-1:0]  ld_row_q, ld_row_d;
	logic [NCW-1:0] ld_ncol_q, ld_ncol_d;
	logic           ld_max_q, ld_max_d;

	logic           hp_we;
	logic [HW-1:0]  hp_wa;
	ent_t           hp_wd;
	logic [HW-1:0]  hp_ra0, hp_ra1;
	logic [EW-1:0]  hp_rd0, hp_rd1;
	logic           hp_re0, hp_re1;
	logic           hp_clash;
	ent_t           lent, rent;

	logic [CW-1:0]  lc, rc, blc, brc;
	logic           l_ok, r_ok;
	sel_t           sel;
	logic [HW-1:0]  best;
	logic [HW-1:0]  base;
	logic           rd_phase;

	kwm_heap_mem #(
		.DEPTH (ROWS),
		.AW    (HW),
		.W     (EW)
	) u_heap (
		.clk (clk),
		.we  (hp_we),
		.wa  (hp_wa),
		.wd  (hp_wd),
		.ra0 (hp_ra0),
		.ra1 (hp_ra1),
		.rd0 (hp_rd0),
		.rd1 (hp_rd1)
	);

	assign lent = ent_t'(hp_rd0);
	assign rent = ent_t'(hp_rd1);

	assign lc   = {1'b0, pos_q, 1'b1};
	assign rc   = lc + CW'(1);
	assign l_ok = lc < CW'(ROWS);
	assign r_ok = rc < CW'(ROWS);

	always_comb begin
		sel  = SEL_SELF;
		best = pos_q;
		if (l_ok && lent.val < cur_q.val) begin
			sel  = SEL_LEFT;
			best = lc[HW-1:0];
		end
		if (r_ok && rent.val < ((sel == SEL_LEFT) ? lent.val : cur_q.val)) begin
			sel  = SEL_RIGHT;
			best = rc[HW-1:0];
		end
	end

	assign rd_phase = (state_q == ST_CUR_LD) || (state_q == ST_SIFT && sel != SEL_SELF);
	assign base     = (state_q == ST_SIFT) ? best : pos_q;
	assign blc      = {1'b0, base, 1'b1};
	assign brc      = blc + CW'(1);
	assign hp_re0   = rd_phase && (blc < CW'(ROWS));
	assign hp_re1   = rd_phase && (brc < CW'(ROWS));
	assign hp_ra0   = hp_re0 ? blc[HW-1:0] : '0;
	assign hp_ra1   = hp_re1 ? brc[HW-1:0] : '0;
	assign hp_clash = hp_we && ((hp_re0 && hp_ra0 == hp_wa) || (hp_re1 && hp_ra1 == hp_wa));

	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			pos_q   <= '0;
			emit_q  <= '0;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			emit_q  <= emit_d;
			build_q <= build_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		root_q    <= root_d;
		ld_row_q  <= ld_row_d;
		ld_ncol_q <= ld_ncol_d;
		ld_max_q  <= ld_max_d;
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		emit_d    = emit_q;
		build_d   = build_q;
		cur_d     = cur_q;
		root_d    = root_q;
		ld_row_d  = ld_row_q;
		ld_ncol_d = ld_ncol_q;
		ld_max_d  = ld_max_q;
		hp_we     = 1'b0;
		hp_wa     = pos_q;
		hp_wd     = cur_q;
		mx_ra     = MAW'(int'(idx_q) * ROWS);
		em        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					idx_d   = '0;
					emit_d  = '0;
					state_d = ST_LOAD_RD;
				end
			end
			ST_LOAD_RD: begin
				state_d = ST_LOAD_WR;
			end
			ST_LOAD_WR: begin
				hp_we      = 1'b1;
				hp_wa      = idx_q;
				hp_wd.val  = mx_rd;
				hp_wd.row  = idx_q;
				hp_wd.ncol = NCW'(1);
				if (idx_q == '0) begin
					root_d = hp_wd;
				end
				if (idx_q == HW'(ROWS - 1)) begin
					idx_d   = HW'((ROWS - 1) / 2);
					build_d = 1'b1;
					state_d = ST_FETCH;
				end else begin
					idx_d   = idx_q + HW'(1);
					state_d = ST_LOAD_RD;
				end
			end
			ST_FETCH: begin
				pos_d     = idx_q;
				ld_row_d  = idx_q;
				ld_ncol_d = NCW'(1);
				ld_max_d  = 1'b0;
				state_d   = ST_CUR_LD;
			end
			ST_CUR_LD: begin
				cur_d.val  = ld_max_q ? INT_MAX : mx_rd;
				cur_d.row  = ld_row_q;
				cur_d.ncol = ld_ncol_q;
				state_d    = ST_SIFT;
			end
			ST_SIFT: begin
				hp_we = 1'b1;
				hp_wa = pos_q;
				case (sel)
					SEL_LEFT:  hp_wd = lent;
					SEL_RIGHT: hp_wd = rent;
					default:   hp_wd = cur_q;
				endcase
				if (pos_q == '0) begin
					root_d = hp_wd;
				end
				if (sel == SEL_SELF) begin
					if (build_q && idx_q != '0) begin
						idx_d   = idx_q - HW'(1);
						state_d = ST_FETCH;
					end else begin
						build_d = 1'b0;
						state_d = ST_EMIT;
					end
				end else begin
					pos_d = best;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					em.vld   = 1'b1;
					em.value = root_q.val;
					em.last  = (emit_q == CNW'(ROWS * ROWS - 1));
					if (em.last) begin
						emit_d  = '0;
						state_d = ST_IDLE;
					end else begin
						emit_d   = emit_q + CNW'(1);
						pos_d    = '0;
						ld_row_d = root_q.row;
						mx_ra    = MAW'(int'(root_q.row) * ROWS + int'(root_q.ncol));
						if (root_q.ncol < NCW'(ROWS)) begin
							ld_ncol_d = root_q.ncol + NCW'(1);
							ld_max_d  = 1'b0;
						end else begin
							ld_ncol_d = root_q.ncol;
							ld_max_d  = 1'b1;
						end
						state_d = ST_CUR_LD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEVER(a_heap_rw_clash, hp_clash, "heap read and write hit the same entry")
	`ASSERT_PROP(a_last_idle, em.vld && em.last |=> state_q == ST_IDLE, "merge did not end after final item")
	`ASSERT_NEVER(a_emit_slot, em.vld && !out_free, "item emitted while output register full")
	`ASSERT_PROP(a_start_idle, start && state_q == ST_IDLE |=> state_q == ST_LOAD_RD, "merge start lost")

endmodule

/* sv/kway_merge_sorted_rows.sv */
// Load: input items are accepted while tready is high, that is while no merge is running.
// Merge: the heap is first seeded from the matrix memory, then one heap
// sift runs per non-leaf row before the first result.
// Each result is followed by a sift of the refilled root, with one heap memory
// read per level; a result waits in ST_EMIT while the output register is full.
// Reset (arst_n low) returns the controller to idle; memory contents persist.
module kway_merge_sorted_rows import kwm_pkg::*; #(
	parameter int ROWS = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // row[1:0], col[3:2], value[35:4], zero[39:36]
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // value_res[31:0]
	output logic        m_tlast   // last_res
);

	localparam int MAW = $clog2(ROWS * ROWS);

	logic                     acc;
	logic [1:0]               in_row, in_col;
	logic signed [DATA_W-1:0] in_value;
	logic                     mx_we;
	logic [MAW-1:0]           mx_wa, mx_ra;
	logic signed [DATA_W-1:0] mx_rd;
	logic                     idle;
	logic                     out_free;
	emit_t                    em;

	logic                     out_vld_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic                     out_last_q;

	assign in_row   = s_tdata[1:0];
	assign in_col   = s_tdata[3:2];
	assign in_value = s_tdata[35:4];

	assign s_tready = idle;
	assign acc      = s_tvalid && s_tready;
	assign mx_we    = acc && (int'(in_row) < ROWS) && (int'(in_col) < ROWS);
	assign mx_wa    = MAW'(int'(in_row) * ROWS + int'(in_col));

	kwm_matrix_mem #(
		.DEPTH (ROWS * ROWS),
		.AW    (MAW)
	) u_matrix (
		.clk (clk),
		.we  (mx_we),
		.wa  (mx_wa),
		.wd  (in_value),
		.ra  (mx_ra),
		.rd  (mx_rd)
	);

	kwm_ctrl #(
		.ROWS (ROWS),
		.MAW  (MAW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && s_tlast),
		.out_free (out_free),
		.idle     (idle),
		.em       (em),
		.mx_ra    (mx_ra),
		.mx_rd    (mx_rd)
	);

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (em.vld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em.vld) begin
			out_data_q <= em.value;
			out_last_q <= em.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

/* tb/tb_kway_merge_sorted_rows.sv */
`timescale 1ns / 1ps

module tb_kway_merge_sorted_rows;
	import kwm_pkg::*;

	localparam int NROWS = ROWS_DEF;
	localparam int NCELLS = NROWS * NROWS;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] val;
		int                 rowi;
		int                 ncol;
	} heap_ent_t;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} sorted_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // row[1:0], col[3:2], value[35:4], zero[39:36]
	logic        s_tlast = 1'b0;  // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // value_res[31:0]
	logic        m_tlast;  // last_res

	logic signed [31:0] matrix_model [NCELLS];
	heap_ent_t          heap_model [NROWS];
	sorted_out_t        sorted_q [$];
	sorted_out_t        want;
	int                 fail_count = 0;
	int                 gap_max = 17;
	int                 stall_max = 17;

	kway_merge_sorted_rows #(.ROWS(NROWS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void sift_model(input int start);
		int p;
		int lc;
		int rc;
		int best;
		bit done;
		heap_ent_t t;
		p = start;
		done = 1'b0;
		while (!done) begin
			lc = 2 * p + 1;
			rc = 2 * p + 2;
			best = p;
			if (lc < NROWS && heap_model[lc].val < heap_model[p].val)
				best = lc;
			if (rc < NROWS && heap_model[rc].val < heap_model[best].val)
				best = rc;
			if (best == p) begin
				done = 1'b1;
			end else begin
				t = heap_model[p];
				heap_model[p] = heap_model[best];
				heap_model[best] = t;
				p = best;
			end
		end
	endfunction

	function automatic void predict_merge();
		int i;
		int e;
		heap_ent_t top;
		sorted_out_t item;
		for (i = 0; i < NROWS; i++) begin
			heap_model[i].val = matrix_model[i * NROWS];
			heap_model[i].rowi = i;
			heap_model[i].ncol = 1;
		end
		for (i = (NROWS - 1) / 2; i >= 0; i--)
			sift_model(i);
		for (e = 0; e < NCELLS; e++) begin
			top = heap_model[0];
			item.value = top.val;
			item.last = (e == NCELLS - 1);
			sorted_q.push_back(item);
			if (top.ncol < NROWS) begin
				top.val = matrix_model[top.rowi * NROWS + top.ncol];
				top.ncol++;
			end else begin
				top.val = INT_MAX;
			end
			heap_model[0] = top;
			sift_model(0);
		end
	endfunction

	function automatic int draw_value();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 6) - 3;
			1: begin
				case ($urandom_range(0, 3))
					0: v = INT_MIN;
					1: v = INT_MAX;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic push_elem(input logic [1:0] r, input logic [1:0] c,
			input logic signed [31:0] v, input logic lst);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, v, c, r};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		matrix_model[r * NROWS + c] = v;
		if (lst)
			predict_merge();
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sorted_q.size() != 0);
	endtask

	task automatic test_directed_extremes();
		logic signed [31:0] grid [NCELLS];
		int k;
		grid = '{INT_MIN, -32'sd1, 32'sd0, INT_MAX,
			-32'sd5, -32'sd5, 32'sd3, 32'sd3,
			32'sd3, 32'sd3, 32'sd100, INT_MAX,
			INT_MAX, INT_MAX, INT_MAX, INT_MAX};
		for (k = 0; k < NCELLS; k++)
			push_elem(2'(k / NROWS), 2'(k % NROWS), grid[k], k == NCELLS - 1);
	endtask

	task automatic test_unsorted_and_repeat();
		push_elem(2'd3, 2'd0, INT_MIN, 1'b0);
		push_elem(2'd0, 2'd2, 32'sh5555_5555, 1'b1);
		pause_until_drained();
		push_elem(2'd1, 2'd1, 32'shAAAA_AAAA, 1'b1);
	endtask

	task automatic load_sorted_set();
		int vals [$];
		logic signed [31:0] grid [NCELLS];
		int r;
		int c;
		int k;
		int start;
		int stride;
		int pos;
		for (r = 0; r < NROWS; r++) begin
			vals.delete();
			for (c = 0; c < NROWS; c++)
				vals.push_back(draw_value());
			vals.sort();
			for (c = 0; c < NROWS; c++)
				grid[r * NROWS + c] = vals[c];
		end
		start = $urandom_range(0, NCELLS - 1);
		stride = 2 * $urandom_range(0, NCELLS / 2 - 1) + 1;
		for (k = 0; k < NCELLS; k++) begin
			pos = (start + k * stride) % NCELLS;
			push_elem(2'(pos / NROWS), 2'(pos % NROWS), grid[pos], k == NCELLS - 1);
		end
	endtask

	task automatic test_sorted_sets();
		int s;
		for (s = 0; s < 10; s++) begin
			case (s % 4)
				0: begin gap_max = 17; stall_max = 17; end
				1: begin gap_max = 0; stall_max = 0; end
				2: begin gap_max = 0; stall_max = 17; end
				default: begin gap_max = 17; stall_max = 0; end
			endcase
			load_sorted_set();
		end
		gap_max = 17;
		stall_max = 17;
	endtask

	task automatic test_noise_and_rewrites();
		int k;
		for (k = 0; k < 90; k++) begin
			if (k == 45) begin
				gap_max = 3;
				stall_max = 3;
			end
			push_elem(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), draw_value(),
				k == 89 || $urandom_range(0, 9) == 0);
		end
		gap_max = 17;
		stall_max = 17;
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			int n;
			n = $urandom_range(0, stall_max);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				$error("value_res with nothing expected: actual %0d", $signed(m_tdata));
				fail_count++;
			end else begin
				want = sorted_q.pop_front();
				if (m_tdata !== want.value) begin
					$error("value_res: expected %0d, actual %0d", want.value,
						$signed(m_tdata));
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_res: expected %0d, actual %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_unsorted_and_repeat();
		test_sorted_sets();
		pause_until_drained();
		test_noise_and_rewrites();
		s_tvalid <= 1'b0;
		for (n = 0; n < 100000 && sorted_q.size() != 0; n++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && sorted_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			if (sorted_q.size() != 0)
				$error("%0d expected values never arrived", sorted_q.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
